[rtl/generational_slot_table_defines.svh]
// Assertion macros shared by the checker of the generational slot table.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef GENERATIONAL_SLOT_TABLE_DEFINES_SVH
`define GENERATIONAL_SLOT_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GST_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("generational slot table check failed");

// The consequent must hold in the cycle after the antecedent.
`define GST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("generational slot table check failed");

`endif

[rtl/gst_pkg.sv]
// Package for the generational slot table: sizes, command and status codes,
// the slot word layout and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package gst_pkg;

   localparam int SLOTS      = 256;
   localparam int DATA_WIDTH = 32;
   localparam int GEN_W      = 32;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_GET    = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // One memory word per slot. A generation of zero marks a free slot.
   typedef struct packed {
      logic [GEN_W-1:0]      gen;
      logic [CNT_W-1:0]      free_link;
      logic [DATA_WIDTH-1:0] payload;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

[rtl/generational_slot_table.sv]
// Generational slot table: hands out index/generation handles for stored data.
// Depends on gst_pkg; the slot state lives in one internal synchronous memory.
`timescale 1ns / 1ps

// The beat accepted at an edge where start is high and busy is low reads its slot
// word from the slot memory; busy is then high for one cycle while the word is
// checked, modified and written back and the free-list head, fill mark, live count
// and generation are updated. The result appears with rsp_valid in the following
// cycle, for exactly one cycle, and a new command may be accepted in that same
// cycle. The receiver cannot stall: each result beat must be taken in the cycle that
// shows it. No new command is accepted during the read-then-write pass through the
// slot memory. The table needs no clearing after reset.
module generational_slot_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_handle_index,
   input  logic [31:0] req_handle_gen,
   input  logic [31:0] req_data_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_out_index,
   output logic [31:0] rsp_out_gen,
   output logic [31:0] rsp_out_data,
   output logic [8:0]  rsp_live_count
);

   gst_pkg::slot_type slot_mem [gst_pkg::SLOTS];

   gst_pkg::state_type state_ff, state_in;

   logic                            accept;
   logic [gst_pkg::IDX_W-1:0]       rd_addr;
   gst_pkg::slot_type               rd_word_ff;

   logic [1:0]                      cmd_ff;
   logic [gst_pkg::IDX_W-1:0]       hidx_ff;
   logic [gst_pkg::GEN_W-1:0]       hgen_ff;
   logic [gst_pkg::DATA_WIDTH-1:0]  data_ff;

   logic [gst_pkg::CNT_W-1:0]       used_mark_ff, used_mark_in;
   logic [gst_pkg::CNT_W-1:0]       free_head_ff, free_head_in;
   logic [gst_pkg::CNT_W-1:0]       occupied_ff, occupied_in;
   logic [gst_pkg::GEN_W-1:0]       cur_gen_ff, cur_gen_in;

   logic                            wr_en;
   logic [gst_pkg::IDX_W-1:0]       wr_addr;
   gst_pkg::slot_type               wr_word;

   logic                            handle_ok;
   logic [1:0]                      status_in;
   logic [gst_pkg::IDX_W-1:0]       oidx_in;
   logic [gst_pkg::GEN_W-1:0]       ogen_in;
   logic [gst_pkg::DATA_WIDTH-1:0]  odata_in;

   logic                            rsp_valid_ff;
   logic [1:0]                      rsp_status_ff;
   logic [gst_pkg::IDX_W-1:0]       rsp_index_ff;
   logic [gst_pkg::GEN_W-1:0]       rsp_gen_ff;
   logic [gst_pkg::DATA_WIDTH-1:0]  rsp_data_ff;
   logic [gst_pkg::CNT_W-1:0]       rsp_count_ff;

   assign busy   = (state_ff == gst_pkg::ST_EXEC);
   assign accept = start && !busy;

   // A push reads the free-list head to fetch its link; other commands read the handle.
   assign rd_addr = (req_command == gst_pkg::CMD_PUSH) ?
                    free_head_ff[gst_pkg::IDX_W-1:0] : req_handle_index;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_word_ff <= slot_mem[rd_addr];
      end
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         hidx_ff <= req_handle_index;
         hgen_ff <= req_handle_gen;
         data_ff <= req_data_in[gst_pkg::DATA_WIDTH-1:0];
      end
   end

   assign handle_ok = (gst_pkg::CNT_W'(hidx_ff) < used_mark_ff) &&
                      (rd_word_ff.gen != '0) && (rd_word_ff.gen == hgen_ff);

   always_comb begin
      state_in     = state_ff;
      used_mark_in = used_mark_ff;
      free_head_in = free_head_ff;
      occupied_in  = occupied_ff;
      cur_gen_in   = cur_gen_ff;
      wr_en        = 1'b0;
      wr_addr      = hidx_ff;
      wr_word      = rd_word_ff;
      status_in    = gst_pkg::STATUS_INVALID;
      oidx_in      = '0;
      ogen_in      = '0;
      odata_in     = '0;

      case (state_ff)
         gst_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = gst_pkg::ST_EXEC;
            end
         end
         gst_pkg::ST_EXEC: begin
            state_in = gst_pkg::ST_IDLE;
            case (cmd_ff)
               gst_pkg::CMD_PUSH: begin
                  wr_word.gen     = cur_gen_ff;
                  wr_word.payload = data_ff;
                  if (free_head_ff < gst_pkg::CNT_W'(gst_pkg::SLOTS)) begin
                     wr_en   = 1'b1;
                     wr_addr = free_head_ff[gst_pkg::IDX_W-1:0];
                     free_head_in = (rd_word_ff.free_link > gst_pkg::CNT_W'(gst_pkg::SLOTS)) ?
                                    gst_pkg::CNT_W'(gst_pkg::SLOTS) : rd_word_ff.free_link;
                  end else if (used_mark_ff < gst_pkg::CNT_W'(gst_pkg::SLOTS)) begin
                     wr_en        = 1'b1;
                     wr_addr      = used_mark_ff[gst_pkg::IDX_W-1:0];
                     used_mark_in = used_mark_ff + 1'b1;
                  end
                  if (wr_en) begin
                     occupied_in = occupied_ff + 1'b1;
                     status_in   = gst_pkg::STATUS_OK;
                     oidx_in     = wr_addr;
                     ogen_in     = cur_gen_ff;
                  end else begin
                     status_in = gst_pkg::STATUS_FULL;
                  end
               end
               gst_pkg::CMD_REMOVE: begin
                  if (handle_ok) begin
                     wr_en             = 1'b1;
                     wr_word.gen       = '0;
                     wr_word.free_link = free_head_ff;
                     free_head_in      = gst_pkg::CNT_W'(hidx_ff);
                     if (occupied_ff != '0) begin
                        occupied_in = occupied_ff - 1'b1;
                     end
                     // The generation skips zero on wrap, since zero marks a free slot.
                     cur_gen_in = (cur_gen_ff == '1) ? gst_pkg::GEN_W'(1) : cur_gen_ff + 1'b1;
                     status_in  = gst_pkg::STATUS_OK;
                  end
               end
               gst_pkg::CMD_GET: begin
                  if (handle_ok) begin
                     status_in = gst_pkg::STATUS_OK;
                     odata_in  = rd_word_ff.payload;
                  end
               end
               default: begin
                  status_in = gst_pkg::STATUS_INVALID;
               end
            endcase
         end
         default: begin
            state_in = gst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gst_pkg::ST_IDLE;
         used_mark_ff <= '0;
         free_head_ff <= gst_pkg::CNT_W'(gst_pkg::SLOTS);
         occupied_ff  <= '0;
         cur_gen_ff   <= gst_pkg::GEN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_mark_ff <= used_mark_in;
         free_head_ff <= free_head_in;
         occupied_ff  <= occupied_in;
         cur_gen_ff   <= cur_gen_in;
         rsp_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         rsp_status_ff <= status_in;
         rsp_index_ff  <= oidx_in;
         rsp_gen_ff    <= ogen_in;
         rsp_data_ff   <= odata_in;
         rsp_count_ff  <= occupied_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_index  = 8'(rsp_index_ff);
   assign rsp_out_gen    = 32'(rsp_gen_ff);
   assign rsp_out_data   = 32'(rsp_data_ff);
   assign rsp_live_count = 9'(rsp_count_ff);

endmodule

[rtl/gst_checker.sv]
// Port-level checker for the generational slot table, bound to the top level.
// Depends on gst_pkg and the assertion macros in generational_slot_table_defines.svh.
`timescale 1ns / 1ps
`include "generational_slot_table_defines.svh"

module gst_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_out_index,
   input logic [31:0] rsp_out_gen,
   input logic [8:0]  rsp_live_count
);

   // An accepted beat occupies the block for its execute cycle.
   `GST_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // The execute cycle is always followed by exactly one result beat.
   `GST_ASSERT_NEXT(a_busy_result, clock, reset, busy, rsp_valid && !busy)

   // Only a successful push hands out a handle.
   `GST_ASSERT_SAME(a_no_stray_handle, clock, reset,
      rsp_valid && (rsp_status != gst_pkg::STATUS_OK),
      (rsp_out_index == 8'd0) && (rsp_out_gen == 32'd0))

   // A full table means every slot is live.
   `GST_ASSERT_SAME(a_full_count, clock, reset,
      rsp_valid && (rsp_status == gst_pkg::STATUS_FULL),
      rsp_live_count == 9'(gst_pkg::SLOTS))

endmodule

bind generational_slot_table gst_checker u_gst_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_out_index  (rsp_out_index),
   .rsp_out_gen    (rsp_out_gen),
   .rsp_live_count (rsp_live_count)
);

[dv/gst_tb_pkg.sv]
// Scoreboard for the generational slot table testbench: a cycle-free predictor of
// the slot table and a queue of expected result beats. Depends on gst_pkg.
`timescale 1ns / 1ps

package gst_tb_pkg;

   // The one command code that the table does not define.
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]                     status;
      logic [gst_pkg::IDX_W-1:0]      index;
      logic [gst_pkg::GEN_W-1:0]      gen;
      logic [gst_pkg::DATA_WIDTH-1:0] data;
      logic [gst_pkg::CNT_W-1:0]      count;
   } table_rsp_type;

   typedef struct packed {
      logic [gst_pkg::IDX_W-1:0] index;
      logic [gst_pkg::GEN_W-1:0] gen;
   } slot_handle_type;

   class slot_table_scoreboard;
      logic [gst_pkg::GEN_W-1:0]      slot_gen  [gst_pkg::SLOTS];
      logic [gst_pkg::CNT_W-1:0]      slot_link [gst_pkg::SLOTS];
      logic [gst_pkg::DATA_WIDTH-1:0] slot_data [gst_pkg::SLOTS];
      logic [gst_pkg::CNT_W-1:0]      fill_mark;
      logic [gst_pkg::CNT_W-1:0]      free_head;
      logic [gst_pkg::CNT_W-1:0]      live;
      logic [gst_pkg::GEN_W-1:0]      cur_gen;
      table_rsp_type                  expected_q[$];
      int unsigned                    errors;
      int unsigned                    checked;

      function new();
         for (int i = 0; i < gst_pkg::SLOTS; i++) begin
            slot_gen[i]  = '0;
            slot_link[i] = '0;
            slot_data[i] = '0;
         end
         fill_mark = '0;
         free_head = gst_pkg::CNT_W'(gst_pkg::SLOTS);
         live      = '0;
         cur_gen   = gst_pkg::GEN_W'(1);
         errors    = 0;
         checked   = 0;
      endfunction

      // Only slots below the fill mark have ever been written.
      function bit handle_live(logic [gst_pkg::IDX_W-1:0] idx, logic [gst_pkg::GEN_W-1:0] gen);
         return (gst_pkg::CNT_W'(idx) < fill_mark) && (slot_gen[idx] != '0) &&
                (slot_gen[idx] == gen);
      endfunction

      // Applies one accepted command beat to the predicted table and queues its result.
      function table_rsp_type note_command(logic [1:0] cmd, logic [gst_pkg::IDX_W-1:0] idx,
                                           logic [gst_pkg::GEN_W-1:0] gen,
                                           logic [gst_pkg::DATA_WIDTH-1:0] data);
         table_rsp_type             rsp;
         logic [gst_pkg::CNT_W-1:0] slot;
         bit                        got;
         rsp = '0;
         rsp.status = gst_pkg::STATUS_INVALID;
         case (cmd)
            gst_pkg::CMD_PUSH: begin
               got = 1'b1;
               slot = '0;
               if (free_head < gst_pkg::CNT_W'(gst_pkg::SLOTS)) begin
                  slot = free_head;
                  free_head = slot_link[slot[gst_pkg::IDX_W-1:0]];
                  if (free_head > gst_pkg::CNT_W'(gst_pkg::SLOTS))
                     free_head = gst_pkg::CNT_W'(gst_pkg::SLOTS);
               end else if (fill_mark < gst_pkg::CNT_W'(gst_pkg::SLOTS)) begin
                  slot = fill_mark;
                  fill_mark = fill_mark + 1'b1;
               end else begin
                  got = 1'b0;
               end
               if (got) begin
                  slot_gen[slot[gst_pkg::IDX_W-1:0]]  = cur_gen;
                  slot_data[slot[gst_pkg::IDX_W-1:0]] = data;
                  live = live + 1'b1;
                  rsp.status = gst_pkg::STATUS_OK;
                  rsp.index  = slot[gst_pkg::IDX_W-1:0];
                  rsp.gen    = cur_gen;
               end else begin
                  rsp.status = gst_pkg::STATUS_FULL;
               end
            end
            gst_pkg::CMD_REMOVE: begin
               if (handle_live(idx, gen)) begin
                  slot_gen[idx]  = '0;
                  slot_link[idx] = free_head;
                  free_head = gst_pkg::CNT_W'(idx);
                  if (live != '0)
                     live = live - 1'b1;
                  // The generation never takes the value zero, which marks a free slot.
                  cur_gen = (cur_gen == '1) ? gst_pkg::GEN_W'(1) : cur_gen + 1'b1;
                  rsp.status = gst_pkg::STATUS_OK;
               end
            end
            gst_pkg::CMD_GET: begin
               if (handle_live(idx, gen)) begin
                  rsp.status = gst_pkg::STATUS_OK;
                  rsp.data   = slot_data[idx];
               end
            end
            default: ;
         endcase
         rsp.count = live;
         expected_q.push_back(rsp);
         return rsp;
      endfunction

      function void check_result(logic [1:0] status, logic [gst_pkg::IDX_W-1:0] idx,
                                 logic [gst_pkg::GEN_W-1:0] gen,
                                 logic [gst_pkg::DATA_WIDTH-1:0] data,
                                 logic [gst_pkg::CNT_W-1:0] count);
         table_rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with no command outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (status !== want.status) begin
            $error("rsp_status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (idx !== want.index) begin
            $error("rsp_out_index: expected %0d, actual %0d", want.index, idx);
            errors++;
         end
         if (gen !== want.gen) begin
            $error("rsp_out_gen: expected 0x%08h, actual 0x%08h", want.gen, gen);
            errors++;
         end
         if (data !== want.data) begin
            $error("rsp_out_data: expected 0x%08h, actual 0x%08h", want.data, data);
            errors++;
         end
         if (count !== want.count) begin
            $error("rsp_live_count: expected %0d, actual %0d", want.count, count);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

[dv/tb_top.sv]
// Top-level testbench of the generational slot table: drives push, remove, get and
// undefined commands and checks every result beat against gst_tb_pkg's scoreboard.
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_ITEMS   = 1500;
   localparam int PHASE_ITEMS    = 500;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int STALE_DEPTH    = 32;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = gst_pkg::CMD_PUSH;
   logic [7:0]  req_handle_index = '0;
   logic [31:0] req_handle_gen = '0;
   logic [31:0] req_data_in = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_index;
   logic [31:0] rsp_out_gen;
   logic [31:0] rsp_out_data;
   logic [8:0]  rsp_live_count;

   gst_tb_pkg::slot_table_scoreboard sb;
   gst_tb_pkg::slot_handle_type      live_handles[$];
   gst_tb_pkg::slot_handle_type      stale_handles[$];
   int unsigned                      idle_pct = 0;
   int unsigned                      commands_sent = 0;
   int unsigned                      full_refusals = 0;
   int unsigned                      invalid_handles = 0;
   int unsigned                      peak_live = 0;
   int unsigned                      quiet_cycles = 0;

   always #5 clock = ~clock;

   generational_slot_table u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_handle_index (req_handle_index),
      .req_handle_gen   (req_handle_gen),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_index    (rsp_out_index),
      .rsp_out_gen      (rsp_out_gen),
      .rsp_out_data     (rsp_out_data),
      .rsp_live_count   (rsp_live_count)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_out_index, rsp_out_gen, rsp_out_data, rsp_live_count);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Presents one command beat after a random gap, holds it until accepted and then
   // updates the list of handles that the table should consider live.
   task automatic issue(input logic [1:0] cmd, input logic [7:0] idx,
                        input logic [31:0] gen, input logic [31:0] data);
      gst_tb_pkg::table_rsp_type want;
      int                        i;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_command      <= cmd;
      req_handle_index <= idx;
      req_handle_gen   <= gen;
      req_data_in      <= data;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      want = sb.note_command(cmd, idx, gen, data);
      commands_sent++;
      if (want.status == gst_pkg::STATUS_FULL)
         full_refusals++;
      if (want.status == gst_pkg::STATUS_INVALID)
         invalid_handles++;
      if (want.count > peak_live)
         peak_live = want.count;
      if (cmd == gst_pkg::CMD_PUSH && want.status == gst_pkg::STATUS_OK)
         live_handles.push_back('{want.index, want.gen});
      if (cmd == gst_pkg::CMD_REMOVE && want.status == gst_pkg::STATUS_OK) begin
         for (i = 0; i < live_handles.size(); i++) begin
            if (live_handles[i].index == idx) begin
               stale_handles.push_back(live_handles[i]);
               live_handles.delete(i);
               break;
            end
         end
         if (stale_handles.size() > STALE_DEPTH)
            void'(stale_handles.pop_front());
      end
   endtask

   // Mostly well-formed traffic on live handles; the filling flag tilts it toward
   // pushes or removes so the table sweeps between empty and full.
   task automatic random_item(input bit filling);
      int unsigned                 roll;
      gst_tb_pkg::slot_handle_type h;
      logic [1:0]                  cmd;
      roll = $urandom_range(99);
      if (roll >= 90) begin
         issue(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom(), $urandom());
         return;
      end
      if (roll < (filling ? 60 : 15) || live_handles.size() == 0) begin
         issue(gst_pkg::CMD_PUSH, 8'($urandom()), $urandom(), $urandom());
         return;
      end
      cmd = (roll < (filling ? 75 : 70)) ? gst_pkg::CMD_REMOVE : gst_pkg::CMD_GET;
      h = live_handles[$urandom_range(live_handles.size() - 1)];
      case ($urandom_range(9))
         0: begin
            if (stale_handles.size() != 0)
               h = stale_handles[$urandom_range(stale_handles.size() - 1)];
         end
         1: h.gen = h.gen ^ (32'h1 << $urandom_range(31));
         default: ;
      endcase
      issue(cmd, h.index, h.gen, $urandom());
   endtask

   initial begin
      bit          filling;
      int unsigned full_hits;
      sb = new();
      filling = 1'b1;
      full_hits = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Handles against an empty table are out of range.
      issue(gst_pkg::CMD_GET, 8'd0, 32'd1, 32'h0);
      issue(gst_pkg::CMD_REMOVE, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(gst_tb_pkg::CMD_UNKNOWN, 8'd0, 32'd0, 32'h1234_5678);
      issue(gst_pkg::CMD_PUSH, 8'd0, 32'd0, 32'h0000_0000);
      issue(gst_pkg::CMD_PUSH, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(gst_pkg::CMD_PUSH, 8'd0, 32'd0, 32'h5A5A_A5A5);
      issue(gst_pkg::CMD_GET, 8'd0, 32'd1, 32'h0);
      issue(gst_pkg::CMD_GET, 8'd1, 32'd1, 32'h0);
      issue(gst_pkg::CMD_GET, 8'd1, 32'd2, 32'h0);
      issue(gst_pkg::CMD_GET, 8'd3, 32'd1, 32'h0);
      issue(gst_pkg::CMD_GET, 8'd255, 32'd1, 32'h0);
      issue(gst_pkg::CMD_REMOVE, 8'd0, 32'd1, 32'h0);
      // A second remove of the same handle finds the slot free.
      issue(gst_pkg::CMD_REMOVE, 8'd0, 32'd1, 32'h0);
      issue(gst_pkg::CMD_GET, 8'd0, 32'd0, 32'h0);
      issue(gst_pkg::CMD_REMOVE, 8'd1, 32'd1, 32'h0);
      issue(gst_pkg::CMD_PUSH, 8'd0, 32'd0, 32'hA5A5_5A5A);
      issue(gst_pkg::CMD_PUSH, 8'd0, 32'd0, 32'h8000_0001);
      issue(gst_pkg::CMD_PUSH, 8'd0, 32'd0, 32'h7FFF_FFFE);
      issue(gst_pkg::CMD_GET, 8'd1, 32'd1, 32'h0);
      issue(gst_tb_pkg::CMD_UNKNOWN, 8'd1, 32'd3, 32'h0);
      issue(gst_pkg::CMD_GET, 8'd1, 32'd3, 32'h0);
      issue(gst_pkg::CMD_REMOVE, 8'd2, 32'd1, 32'h0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (n / PHASE_ITEMS)
            0: idle_pct = 0;
            1: idle_pct = 81;
            default: idle_pct = 33;
         endcase
         // Within each phase, some stretches run with no gaps at all.
         if ((n % 100) >= 80)
            idle_pct = 0;
         random_item(filling);
         if (filling && live_handles.size() == gst_pkg::SLOTS) begin
            full_hits++;
            if (full_hits > 6) begin
               filling = 1'b0;
               full_hits = 0;
            end
         end
         if (!filling && live_handles.size() < 4)
            filling = 1'b1;
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Covered %0d commands: %0d pushes refused on a full table, %0d stale or invalid.",
               commands_sent, full_refusals, invalid_handles);
      $display("Compared %0d result beats; peak occupancy %0d of %0d slots.",
               sb.checked, peak_live, gst_pkg::SLOTS);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
